### hw/rtl/text_glyph_blitter_core_assert.svh
// Assertion macros for the glyph blitter core.
// TGB_ASSERT is gated by reset, TGB_ASSERT_ALWAYS also checks through reset.
`ifndef TEXT_GLYPH_BLITTER_CORE_ASSERT_SVH
`define TEXT_GLYPH_BLITTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TGB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGB_ASSERT(lbl, clk, rst, prop, msg)
`define TGB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/tgb_pkg.sv
`default_nettype none
package tgb_pkg;

   // frame and atlas geometry
   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 128;
   localparam int ATLAS_WIDTH  = 32;
   localparam int ATLAS_ROWS   = 256;
   localparam int ATLAS_AW     = $clog2(ATLAS_ROWS);
   localparam int ATLAS_SW     = $clog2(ATLAS_WIDTH);

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 6;

   localparam logic [CSR_IW-1:0] REG_GLYPH_WIDTH   = 2'd0;
   localparam logic [CSR_IW-1:0] REG_GLYPH_HEIGHT  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_ATLAS_COLUMNS = 2'd2;

   localparam logic [1:0] OP_MAP    = 2'd0;
   localparam logic [1:0] OP_LOAD   = 2'd1;
   localparam logic [1:0] OP_RENDER = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_CHAR = 2'd1;
   localparam logic [1:0] STATUS_OFF     = 2'd2;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [7:0]  slot;
      logic        slot_valid;
      logic [7:0]  atlas_row;
      logic [31:0] atlas_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] dest_x;
      logic [6:0] dest_y;
      logic [7:0] pixel_bits;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DIV,
      ST_MUL_ROW,
      ST_MUL_BIT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_CHECK,
      ST_ROW_RD,
      ST_ROW_OUT
   } state_type;

   function automatic logic [3:0] clamp_gw(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (v > 4'd8) r = 4'd8;
      return r;
   endfunction

   function automatic logic [4:0] clamp_gh(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      if (v == 5'd0) r = 5'd1;
      else if (v > 5'd16) r = 5'd16;
      return r;
   endfunction

   function automatic logic [5:0] clamp_cols(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      if (v == 6'd0) r = 6'd1;
      else if (v > 6'd32) r = 6'd32;
      return r;
   endfunction

   function automatic logic [7:0] pix_mask(input logic [3:0] gw);
      logic [8:0] m;
      m = (9'd1 << gw) - 9'd1;
      return m[7:0];
   endfunction

endpackage
`default_nettype wire

### hw/rtl/text_glyph_blitter_core.sv
`default_nettype none
// Character-cell text renderer.
// req channel (valid/stall): one transfer carries an op. Map (op 0) writes the
//   character-to-slot table, load (op 1) writes one atlas row, render (op 2)
//   draws one character at the text cursor. Map, load, newline and op 3
//   produce nothing; a new item may follow in the next cycle.
// rsp channel (valid/stall): one transfer per glyph row (dest_x, dest_y,
//   pixel_bits, last), or a single error transfer with last set when the
//   character is unmapped or the glyph cell leaves the frame.
// csr port: glyph_width, glyph_height, atlas_columns; written while idle.
// Sequence from a render transfer to its result in the output register: an
//   unmapped character reports from the lookup. A mapped one runs lookup,
//   slot divide by atlas_columns (one quotient bit per cycle), four products
//   on the shared 8x5 multiplier, frame check and first atlas read, then one
//   row per cycle while the receiver does not stall; the next transfer is
//   taken once the last row is loaded. An off-frame glyph reports from the
//   frame check.
// req_stall is high while a render is in progress. When the receiver stalls,
//   the held result stays in the output register and the row sequencer waits.
// Reset clears the slot table valid bits, the cursor, the registers (width 8,
//   height 8, 4 columns) and the output valid. The atlas is not cleared.
module text_glyph_blitter_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire tgb_pkg::req_type           req_payload,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      tgb_pkg::rsp_type           rsp_payload,
   input  wire logic                       csr_wen,
   input  wire logic [tgb_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [tgb_pkg::CSR_DW-1:0] csr_wdata
);

   // configuration
   logic [3:0] gw_ff;
   logic [4:0] gh_ff;
   logic [5:0] cols_ff;
   logic [3:0] gw_c;
   logic [4:0] gh_c;
   logic [5:0] cols_c;

   // sequencer
   tgb_pkg::state_type state_ff, state_in;

   // slot table: valid bits in flops, slot numbers in memory
   logic [255:0] slot_vld_ff;
   logic [7:0]   slot_mem [256];
   logic [7:0]   slot_rd_ff;
   logic         hit_ff;

   // glyph atlas
   logic [tgb_pkg::ATLAS_WIDTH-1:0] atlas_mem [tgb_pkg::ATLAS_ROWS];
   logic [tgb_pkg::ATLAS_WIDTH-1:0] atlas_rd_ff;
   logic                            atlas_we;
   logic                            atlas_re;
   logic [tgb_pkg::ATLAS_AW-1:0]    atlas_ra;

   // divider
   logic [7:0] div_dvd_ff;
   logic [5:0] div_rem_ff;
   logic [2:0] div_cnt_ff;
   logic [6:0] div_trial;
   logic [6:0] div_diff;
   logic       div_ge;

   // shared multiplier
   logic [7:0]  mul_a;
   logic [4:0]  mul_b;
   logic [12:0] mul_p;

   // glyph geometry
   logic [12:0] row_addr_ff;
   logic [12:0] row_addr_nx;
   logic [7:0]  bit0_ff;
   logic [10:0] x0_ff;
   logic [10:0] y_ff;
   logic [3:0]  row_cnt_ff;
   logic        last_row;
   logic        off_frame;
   logic [11:0] x_end;
   logic [11:0] y_end;
   logic        atlas_hit;
   logic [tgb_pkg::ATLAS_WIDTH-1:0] atlas_shift;
   logic [7:0]  row_pix;

   // cursor
   logic [7:0] cursor_col_ff;
   logic [6:0] cursor_line_ff;

   // handshakes
   logic             req_acc;
   logic             is_render;
   logic             is_nl;
   logic             rsp_valid_ff;
   tgb_pkg::rsp_type rsp_payload_ff;
   tgb_pkg::rsp_type rsp_next;
   logic             rsp_free;
   logic             rsp_load;
   logic             row_step;

   assign gw_c   = tgb_pkg::clamp_gw(gw_ff);
   assign gh_c   = tgb_pkg::clamp_gh(gh_ff);
   assign cols_c = tgb_pkg::clamp_cols(cols_ff);

   assign req_stall   = (state_ff != tgb_pkg::ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign is_render   = (req_payload.op == tgb_pkg::OP_RENDER);
   assign is_nl       = (req_payload.char_code == tgb_pkg::NEWLINE_CODE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // one restoring-divide step: slot / atlas_columns
   assign div_trial = {div_rem_ff, div_dvd_ff[7]};
   assign div_ge    = (div_trial >= {1'b0, cols_c});
   assign div_diff  = div_trial - {1'b0, cols_c};

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         tgb_pkg::ST_MUL_ROW: begin
            mul_a = div_dvd_ff;
            mul_b = gh_c;
         end
         tgb_pkg::ST_MUL_BIT: begin
            mul_a = {2'b00, div_rem_ff};
            mul_b = {1'b0, gw_c};
         end
         tgb_pkg::ST_MUL_X: begin
            mul_a = cursor_col_ff;
            mul_b = {1'b0, gw_c};
         end
         tgb_pkg::ST_MUL_Y: begin
            mul_a = {1'b0, cursor_line_ff};
            mul_b = gh_c;
         end
         default: begin
            mul_a = 8'd0;
            mul_b = 5'd0;
         end
      endcase
   end
   assign mul_p = 13'(mul_a) * 13'(mul_b);

   // frame bounds check on the glyph cell
   assign x_end     = {1'b0, x0_ff} + 12'(gw_c);
   assign y_end     = {1'b0, y_ff} + 12'(gh_c);
   assign off_frame = (x_end > 12'(tgb_pkg::FRAME_WIDTH)) ||
                      (y_end > 12'(tgb_pkg::FRAME_HEIGHT));

   // row pixels; rows or columns beyond the atlas read as blank
   assign row_addr_nx = row_addr_ff + 13'd1;
   assign last_row    = (5'(row_cnt_ff) + 5'd1) == gh_c;
   assign atlas_hit   = (row_addr_ff < 13'(tgb_pkg::ATLAS_ROWS)) &&
                        ({1'b0, bit0_ff} < 9'(tgb_pkg::ATLAS_WIDTH));
   assign atlas_shift = atlas_rd_ff >> bit0_ff[tgb_pkg::ATLAS_SW-1:0];
   assign row_pix     = atlas_hit ? (atlas_shift[7:0] & tgb_pkg::pix_mask(gw_c)) : 8'd0;

   assign atlas_we = req_acc && (req_payload.op == tgb_pkg::OP_LOAD) &&
                     ({1'b0, req_payload.atlas_row} < 9'(tgb_pkg::ATLAS_ROWS));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tgb_pkg::ST_IDLE: begin
            if (req_acc && is_render && !is_nl) state_in = tgb_pkg::ST_LOOKUP;
         end
         tgb_pkg::ST_LOOKUP: begin
            if (hit_ff) state_in = tgb_pkg::ST_DIV;
            else if (rsp_free) state_in = tgb_pkg::ST_IDLE;
         end
         tgb_pkg::ST_DIV: begin
            if (div_cnt_ff == 3'd7) state_in = tgb_pkg::ST_MUL_ROW;
         end
         tgb_pkg::ST_MUL_ROW: state_in = tgb_pkg::ST_MUL_BIT;
         tgb_pkg::ST_MUL_BIT: state_in = tgb_pkg::ST_MUL_X;
         tgb_pkg::ST_MUL_X:   state_in = tgb_pkg::ST_MUL_Y;
         tgb_pkg::ST_MUL_Y:   state_in = tgb_pkg::ST_CHECK;
         tgb_pkg::ST_CHECK: begin
            if (!off_frame) state_in = tgb_pkg::ST_ROW_RD;
            else if (rsp_free) state_in = tgb_pkg::ST_IDLE;
         end
         tgb_pkg::ST_ROW_RD: state_in = tgb_pkg::ST_ROW_OUT;
         tgb_pkg::ST_ROW_OUT: begin
            if (rsp_free && last_row) state_in = tgb_pkg::ST_IDLE;
         end
         default: state_in = tgb_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      rsp_load = 1'b0;
      row_step = 1'b0;
      atlas_re = 1'b0;
      atlas_ra = row_addr_ff[tgb_pkg::ATLAS_AW-1:0];
      rsp_next = '0;
      case (state_ff)
         tgb_pkg::ST_LOOKUP: begin
            rsp_load        = !hit_ff && rsp_free;
            rsp_next.status = tgb_pkg::STATUS_NO_CHAR;
            rsp_next.last   = 1'b1;
         end
         tgb_pkg::ST_CHECK: begin
            rsp_load        = off_frame && rsp_free;
            rsp_next.status = tgb_pkg::STATUS_OFF;
            rsp_next.last   = 1'b1;
         end
         tgb_pkg::ST_ROW_RD: begin
            atlas_re = 1'b1;
         end
         tgb_pkg::ST_ROW_OUT: begin
            rsp_load            = rsp_free;
            row_step            = rsp_free;
            // fetch the next row while this one goes out
            atlas_re            = rsp_free && !last_row;
            atlas_ra            = row_addr_nx[tgb_pkg::ATLAS_AW-1:0];
            rsp_next.dest_x     = x0_ff[7:0];
            rsp_next.dest_y     = y_ff[6:0];
            rsp_next.pixel_bits = row_pix;
            rsp_next.status     = tgb_pkg::STATUS_OK;
            rsp_next.last       = last_row;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tgb_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         gw_ff          <= 4'd8;
         gh_ff          <= 5'd8;
         cols_ff        <= 6'd4;
         slot_vld_ff    <= '0;
         cursor_col_ff  <= 8'd0;
         cursor_line_ff <= 7'd0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_wen) begin
            case (csr_index)
               tgb_pkg::REG_GLYPH_WIDTH:   gw_ff   <= csr_wdata[3:0];
               tgb_pkg::REG_GLYPH_HEIGHT:  gh_ff   <= csr_wdata[4:0];
               tgb_pkg::REG_ATLAS_COLUMNS: cols_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_acc && (req_payload.op == tgb_pkg::OP_MAP)) begin
            slot_vld_ff[req_payload.char_code] <= req_payload.slot_valid;
         end
         if (req_acc && is_render && is_nl) begin
            cursor_col_ff <= 8'd0;
            if (cursor_line_ff != 7'd127) cursor_line_ff <= cursor_line_ff + 7'd1;
         end else if (row_step && last_row && (cursor_col_ff != 8'd255)) begin
            cursor_col_ff <= cursor_col_ff + 8'd1;
         end
      end
   end

   // slot table memory; lookup issued on the render transfer
   always_ff @(posedge clock) begin
      if (req_acc && (req_payload.op == tgb_pkg::OP_MAP)) begin
         slot_mem[req_payload.char_code] <= req_payload.slot;
      end
      if (req_acc && is_render) begin
         slot_rd_ff <= slot_mem[req_payload.char_code];
         hit_ff     <= slot_vld_ff[req_payload.char_code];
      end
   end

   // atlas memory
   always_ff @(posedge clock) begin
      if (atlas_we) begin
         atlas_mem[req_payload.atlas_row[tgb_pkg::ATLAS_AW-1:0]] <=
            req_payload.atlas_bits[tgb_pkg::ATLAS_WIDTH-1:0];
      end
      if (atlas_re) atlas_rd_ff <= atlas_mem[atlas_ra];
   end

   // datapath
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_payload_ff <= rsp_next;
      case (state_ff)
         tgb_pkg::ST_LOOKUP: begin
            div_dvd_ff <= slot_rd_ff;
            div_rem_ff <= 6'd0;
            div_cnt_ff <= 3'd0;
         end
         tgb_pkg::ST_DIV: begin
            div_dvd_ff <= {div_dvd_ff[6:0], div_ge};
            div_rem_ff <= div_ge ? div_diff[5:0] : div_trial[5:0];
            div_cnt_ff <= div_cnt_ff + 3'd1;
         end
         tgb_pkg::ST_MUL_ROW: row_addr_ff <= mul_p;
         tgb_pkg::ST_MUL_BIT: bit0_ff     <= mul_p[7:0];
         tgb_pkg::ST_MUL_X:   x0_ff       <= mul_p[10:0];
         tgb_pkg::ST_MUL_Y:   y_ff        <= mul_p[10:0];
         tgb_pkg::ST_CHECK:   row_cnt_ff  <= 4'd0;
         tgb_pkg::ST_ROW_OUT: begin
            if (row_step) begin
               row_cnt_ff  <= row_cnt_ff + 4'd1;
               row_addr_ff <= row_addr_nx;
               y_ff        <= y_ff + 11'd1;
            end
         end
         default: begin
         end
      endcase
   end

`include "text_glyph_blitter_core_assert.svh"

   // reset empties the output register and parks the sequencer
   `TGB_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (!rsp_valid_ff && state_ff == tgb_pkg::ST_IDLE),
      "reset did not idle the block")

   // error transfers are single and blank
   `TGB_ASSERT(a_err_single, clock, reset,
      (rsp_valid_ff && rsp_payload_ff.status != tgb_pkg::STATUS_OK) |->
         (rsp_payload_ff.last && rsp_payload_ff.pixel_bits == 8'd0),
      "error result malformed")

   // row counter stays inside the glyph
   `TGB_ASSERT(a_row_bound, clock, reset,
      (state_ff == tgb_pkg::ST_ROW_OUT) |-> (5'(row_cnt_ff) < gh_c),
      "row counter past glyph height")

   // a non-newline render transfer always starts a lookup
   `TGB_ASSERT(a_render_start, clock, reset,
      (req_acc && is_render && !is_nl) |=> (state_ff == tgb_pkg::ST_LOOKUP),
      "render did not start lookup")

endmodule
`default_nettype wire
